>>> rtl/core/ptd_pkg.sv
`default_nettype none
package ptd_pkg;

    localparam int TIME_BITS_DEF = 48;
    localparam int CFG_IDX_BITS  = 2;
    localparam int CFG_DATA_BITS = 16;

    localparam logic [CFG_IDX_BITS-1:0] CFG_DEBOUNCE = 2'd0;
    localparam logic [CFG_IDX_BITS-1:0] CFG_TAIL     = 2'd1;
    localparam logic [CFG_IDX_BITS-1:0] CFG_INVERT   = 2'd2;

    localparam logic CMD_SAMPLE = 1'b0;
    localparam logic CMD_TICK   = 1'b1;

    localparam logic [1:0] ACT_NONE  = 2'd0;
    localparam logic [1:0] ACT_START = 2'd1;
    localparam logic [1:0] ACT_STOP  = 2'd2;

    typedef struct packed {
        logic [15:0] debounce_time;
        logic [15:0] tail_time;
        logic        invert_input;
    } t_cfg;

endpackage
`default_nettype wire

>>> rtl/core/ptd_ifs.sv
`default_nettype none
interface ptd_item_if #(
    parameter int TIME_BITS = ptd_pkg::TIME_BITS_DEF
);
    logic                 valid;
    logic                 ready;
    logic                 command;
    logic                 raw_level;
    logic [TIME_BITS-1:0] now;

    modport source (output valid, output command, output raw_level, output now, input ready);
    modport sink   (input valid, input command, input raw_level, input now, output ready);
endinterface

interface ptd_res_if #(
    parameter int TIME_BITS = ptd_pkg::TIME_BITS_DEF
);
    logic                 valid;
    logic                 ready;
    logic [1:0]           action;
    logic                 deadline_valid;
    logic [TIME_BITS-1:0] next_deadline;

    modport source (output valid, output action, output deadline_valid,
                    output next_deadline, input ready);
    modport sink   (input valid, input action, input deadline_valid,
                    input next_deadline, output ready);
endinterface

interface ptd_cfg_if;
    logic                                 valid;
    logic                                 ready;
    logic [ptd_pkg::CFG_IDX_BITS-1:0]     index;
    logic [ptd_pkg::CFG_DATA_BITS-1:0]    data;

    modport source (output valid, output index, output data, input ready);
    modport sink   (input valid, input index, input data, output ready);
endinterface
`default_nettype wire

>>> rtl/core/ptd_cfg_regs.sv
`default_nettype none
module ptd_cfg_regs (
    input  wire logic                              i_clk,
    input  wire logic                              i_rst_n,
    input  wire logic                              i_valid,
    output logic                                   o_ready,
    input  wire logic [ptd_pkg::CFG_IDX_BITS-1:0]  i_index,
    input  wire logic [ptd_pkg::CFG_DATA_BITS-1:0] i_data,
    output ptd_pkg::t_cfg                          o_cfg
);
    import ptd_pkg::*;

    t_cfg r_cfg;

    assign o_ready = 1'b1;
    assign o_cfg   = r_cfg;

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_cfg <= '0;
        end else if (i_valid) begin
            case (i_index)
                CFG_DEBOUNCE: r_cfg.debounce_time <= i_data;
                CFG_TAIL:     r_cfg.tail_time     <= i_data;
                CFG_INVERT:   r_cfg.invert_input  <= i_data[0];
                default: ;
            endcase
        end
    end
endmodule
`default_nettype wire

>>> rtl/core/ptd_in_stage.sv
`default_nettype none
module ptd_in_stage #(
    parameter int TIME_BITS = ptd_pkg::TIME_BITS_DEF
) (
    input  wire logic                 i_clk,
    input  wire logic                 i_rst_n,
    input  wire logic                 i_valid,
    output logic                      o_ready,
    input  wire logic                 i_command,
    input  wire logic                 i_raw_level,
    input  wire logic [TIME_BITS-1:0] i_now,
    output logic                      o_valid,
    input  wire logic                 i_ready,
    output logic                      o_command,
    output logic                      o_raw_level,
    output logic [TIME_BITS-1:0]      o_now
);
    logic                 r_valid;
    logic                 r_command;
    logic                 r_raw_level;
    logic [TIME_BITS-1:0] r_now;

    assign o_ready     = !r_valid || i_ready;
    assign o_valid     = r_valid;
    assign o_command   = r_command;
    assign o_raw_level = r_raw_level;
    assign o_now       = r_now;

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_valid <= 1'b0;
        end else if (o_ready) begin
            r_valid <= i_valid;
        end
    end

    always_ff @(posedge i_clk) begin
        if (o_ready && i_valid) begin
            r_command   <= i_command;
            r_raw_level <= i_raw_level;
            r_now       <= i_now;
        end
    end
endmodule
`default_nettype wire

>>> rtl/core/ptd_step.sv
`default_nettype none
module ptd_step #(
    parameter int TIME_BITS = ptd_pkg::TIME_BITS_DEF
) (
    input  wire logic                 i_clk,
    input  wire logic                 i_rst_n,
    input  wire ptd_pkg::t_cfg        i_cfg,
    input  wire logic                 i_valid,
    output logic                      o_ready,
    input  wire logic                 i_command,
    input  wire logic                 i_raw_level,
    input  wire logic [TIME_BITS-1:0] i_now,
    output logic                      o_valid,
    input  wire logic                 i_ready,
    output logic [1:0]                o_action,
    output logic                      o_deadline_valid,
    output logic [TIME_BITS-1:0]      o_next_deadline
);
    import ptd_pkg::*;

    localparam int EXT = TIME_BITS + 1 - 16;

    logic                 r_stable;
    logic                 r_cand;
    logic [TIME_BITS-1:0] r_cand_start;
    logic [TIME_BITS-1:0] r_tail;
    logic                 r_tx;
    logic                 r_out_valid;
    logic [1:0]           r_action;
    logic                 r_dl_valid;
    logic [TIME_BITS-1:0] r_dl;

    logic                 n_stable;
    logic                 n_cand;
    logic [TIME_BITS-1:0] n_cand_start;
    logic [TIME_BITS-1:0] n_tail;
    logic                 n_tx;
    logic [1:0]           n_action;
    logic                 n_dl_valid;
    logic [TIME_BITS-1:0] n_dl;

    logic                 fire;
    logic                 pressed;
    logic [TIME_BITS:0]   sum_cs;
    logic [TIME_BITS:0]   sum_now_db;
    logic [TIME_BITS:0]   sum_now_tail;
    logic [TIME_BITS:0]   cand_sum;
    logic [TIME_BITS-1:0] cand_dl;
    logic [TIME_BITS-1:0] tail_arm;
    logic                 settle_ok;
    logic                 tail_hit;
    logic                 chk;
    logic                 cs_from_now;

    assign fire    = i_valid && (!r_out_valid || i_ready);
    assign o_ready = !r_out_valid || i_ready;

    assign o_valid          = r_out_valid;
    assign o_action         = r_action;
    assign o_deadline_valid = r_dl_valid;
    assign o_next_deadline  = r_dl;

    always_comb begin
        pressed      = ~i_raw_level ^ i_cfg.invert_input;
        sum_cs       = {1'b0, r_cand_start} + {{EXT{1'b0}}, i_cfg.debounce_time};
        sum_now_db   = {1'b0, i_now} + {{EXT{1'b0}}, i_cfg.debounce_time};
        sum_now_tail = {1'b0, i_now} + {{EXT{1'b0}}, i_cfg.tail_time};
        tail_arm     = sum_now_tail[TIME_BITS] ? '1 : sum_now_tail[TIME_BITS-1:0];
        settle_ok    = (i_cfg.debounce_time == '0) || ({1'b0, i_now} >= sum_cs);
        tail_hit     = (r_tail != '0) && (i_now >= r_tail);

        n_stable     = r_stable;
        n_cand       = r_cand;
        n_cand_start = r_cand_start;
        n_tail       = r_tail;
        n_tx         = r_tx;
        n_action     = ACT_NONE;
        chk          = 1'b0;
        cs_from_now  = 1'b0;

        if (i_command == CMD_TICK) begin
            chk = 1'b1;
        end else if (pressed == r_stable) begin
            n_cand_start = '0;
            chk          = 1'b1;
        end else if (r_cand_start == '0 || r_cand != pressed) begin
            n_cand       = pressed;
            n_cand_start = i_now;
            cs_from_now  = 1'b1;
            chk          = 1'b1;
        end else if (settle_ok) begin
            n_cand_start = '0;
            n_stable     = pressed;
            if (pressed) begin
                n_tail = '0;
                if (!r_tx) begin
                    n_tx     = 1'b1;
                    n_action = ACT_START;
                end
            end else if (r_tx) begin
                if (i_cfg.tail_time == '0) begin
                    n_tx     = 1'b0;
                    n_action = ACT_STOP;
                end else begin
                    n_tail = tail_arm;
                end
            end
        end else begin
            chk = 1'b1;
        end

        if (chk && tail_hit) begin
            n_tail = '0;
            if (r_tx) begin
                n_tx     = 1'b0;
                n_action = ACT_STOP;
            end
        end

        cand_sum   = cs_from_now ? sum_now_db : sum_cs;
        cand_dl    = cand_sum[TIME_BITS] ? '1 : cand_sum[TIME_BITS-1:0];
        n_dl_valid = (n_tail != '0) || (n_cand_start != '0);
        n_dl       = n_tail;
        if (n_cand_start != '0 && (n_tail == '0 || cand_dl < n_tail)) begin
            n_dl = cand_dl;
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_stable     <= 1'b0;
            r_cand       <= 1'b0;
            r_cand_start <= '0;
            r_tail       <= '0;
            r_tx         <= 1'b0;
            r_out_valid  <= 1'b0;
        end else begin
            if (fire) begin
                r_stable     <= n_stable;
                r_cand       <= n_cand;
                r_cand_start <= n_cand_start;
                r_tail       <= n_tail;
                r_tx         <= n_tx;
            end
            if (o_ready) begin
                r_out_valid <= i_valid;
            end
        end
    end

    always_ff @(posedge i_clk) begin
        if (fire) begin
            r_action   <= n_action;
            r_dl_valid <= n_dl_valid;
            r_dl       <= n_dl;
        end
    end
endmodule
`default_nettype wire

>>> rtl/core/ptt_debounce_tail_hold.sv
// Push-to-talk debouncer with tail hold. Each accepted beat (a level sample or
// a time tick carrying a millisecond timestamp) yields exactly one result beat
// with the transmit action and the earliest pending deadline. The block takes
// one beat per cycle; a beat goes through an input register and one pass of
// compare/add logic into the result register, and backpressure on the result
// side stalls the input only when both registers are full. Configuration
// (debounce ms, tail ms, input inversion) is to be written through the
// register port between beats; the block does not enforce this. The port is
// always ready.
`default_nettype none
module ptt_debounce_tail_hold #(
    parameter int TIME_BITS = ptd_pkg::TIME_BITS_DEF
) (
    input  wire logic  i_clk,
    input  wire logic  i_rst_n,
    ptd_item_if.sink   i_item,
    ptd_res_if.source  o_res,
    ptd_cfg_if.sink    i_cfg
);
    import ptd_pkg::*;

    t_cfg                 cfg;
    logic                 st_valid;
    logic                 st_ready;
    logic                 st_command;
    logic                 st_raw_level;
    logic [TIME_BITS-1:0] st_now;

    ptd_cfg_regs u_cfg (
        .i_clk   (i_clk),
        .i_rst_n (i_rst_n),
        .i_valid (i_cfg.valid),
        .o_ready (i_cfg.ready),
        .i_index (i_cfg.index),
        .i_data  (i_cfg.data),
        .o_cfg   (cfg)
    );

    ptd_in_stage #(.TIME_BITS(TIME_BITS)) u_in (
        .i_clk       (i_clk),
        .i_rst_n     (i_rst_n),
        .i_valid     (i_item.valid),
        .o_ready     (i_item.ready),
        .i_command   (i_item.command),
        .i_raw_level (i_item.raw_level),
        .i_now       (i_item.now),
        .o_valid     (st_valid),
        .i_ready     (st_ready),
        .o_command   (st_command),
        .o_raw_level (st_raw_level),
        .o_now       (st_now)
    );

    ptd_step #(.TIME_BITS(TIME_BITS)) u_step (
        .i_clk            (i_clk),
        .i_rst_n          (i_rst_n),
        .i_cfg            (cfg),
        .i_valid          (st_valid),
        .o_ready          (st_ready),
        .i_command        (st_command),
        .i_raw_level      (st_raw_level),
        .i_now            (st_now),
        .o_valid          (o_res.valid),
        .i_ready          (o_res.ready),
        .o_action         (o_res.action),
        .o_deadline_valid (o_res.deadline_valid),
        .o_next_deadline  (o_res.next_deadline)
    );
endmodule
`default_nettype wire

>>> dv/tb_top.sv
`timescale 1ns / 1ps

module tb_top;
    import ptd_pkg::*;

    localparam int          TB_TIME    = 48;
    localparam logic [47:0] T_MAX      = '1;
    localparam int          IDLE_PCT   = 6;
    localparam int          STALL_LIMIT = 3000;

    typedef struct packed {
        logic [1:0]         action;
        logic               dl_valid;
        logic [TB_TIME-1:0] deadline;
    } t_exp_res;

    logic i_clk;
    logic i_rst_n;

    ptd_item_if #(.TIME_BITS(TB_TIME)) item_if ();
    ptd_res_if  #(.TIME_BITS(TB_TIME)) res_if ();
    ptd_cfg_if                         cfg_if ();

    ptt_debounce_tail_hold #(.TIME_BITS(TB_TIME)) i_dut (
        .i_clk   (i_clk),
        .i_rst_n (i_rst_n),
        .i_item  (item_if),
        .o_res   (res_if),
        .i_cfg   (cfg_if)
    );

    initial i_clk = 1'b0;
    always begin
        #5 i_clk = 1'b1;
        #5 i_clk = 1'b0;
    end

    // predictor copy of the block
    logic [15:0]        p_debounce;
    logic [15:0]        p_tail;
    logic               p_invert;
    logic               st_pressed;
    logic               cand_down;
    logic [TB_TIME-1:0] cand_start;
    logic [TB_TIME-1:0] tail_exp;
    logic               tx_on;

    t_exp_res due_results[$];
    int       n_err;
    int       n_beats;
    int       n_ticks;
    int       n_checked;
    int       n_start;
    int       n_stop;
    int       n_cfg;
    bit       calm;
    int       quiet_cycles;

    function automatic logic [TB_TIME-1:0] time_sat_add(input logic [TB_TIME-1:0] a,
                                                         input logic [15:0] b);
        logic [TB_TIME:0] sum;
        sum = {1'b0, a} + {{(TB_TIME-15){1'b0}}, b};
        return sum[TB_TIME] ? T_MAX : sum[TB_TIME-1:0];
    endfunction

    function automatic logic [1:0] tail_due(input logic [TB_TIME-1:0] now);
        if (tail_exp != '0 && now >= tail_exp) begin
            tail_exp = '0;
            if (tx_on) begin
                tx_on = 1'b0;
                return ACT_STOP;
            end
        end
        return ACT_NONE;
    endfunction

    function automatic logic [1:0] accept_level(input logic pressed,
                                                input logic [TB_TIME-1:0] now);
        st_pressed = pressed;
        if (pressed) begin
            tail_exp = '0;
            if (!tx_on) begin
                tx_on = 1'b1;
                return ACT_START;
            end
            return ACT_NONE;
        end
        if (tx_on) begin
            if (p_tail == '0) begin
                tx_on = 1'b0;
                return ACT_STOP;
            end
            tail_exp = time_sat_add(now, p_tail);
        end
        return ACT_NONE;
    endfunction

    function automatic logic [1:0] level_sample(input logic raw, input logic [TB_TIME-1:0] now);
        logic               pressed;
        logic [TB_TIME-1:0] elapsed;
        pressed = ~raw ^ p_invert;
        if (pressed == st_pressed) begin
            cand_start = '0;
            return tail_due(now);
        end
        if (cand_start == '0 || cand_down != pressed) begin
            cand_down  = pressed;
            cand_start = now;
            return tail_due(now);
        end
        elapsed = (now >= cand_start) ? now - cand_start : '0;
        if (elapsed >= {{(TB_TIME-16){1'b0}}, p_debounce}) begin
            cand_start = '0;
            return accept_level(pressed, now);
        end
        return tail_due(now);
    endfunction

    function automatic t_exp_res ptt_next_result(input logic cmd, input logic raw,
                                                 input logic [TB_TIME-1:0] now);
        t_exp_res           r;
        logic [TB_TIME-1:0] c;
        r.action   = (cmd == CMD_TICK) ? tail_due(now) : level_sample(raw, now);
        r.dl_valid = 1'b0;
        r.deadline = '0;
        if (tail_exp != '0) begin
            r.dl_valid = 1'b1;
            r.deadline = tail_exp;
        end
        if (cand_start != '0) begin
            c = time_sat_add(cand_start, p_debounce);
            if (!r.dl_valid || c < r.deadline) r.deadline = c;
            r.dl_valid = 1'b1;
        end
        return r;
    endfunction

    // result side: random backpressure and compare
    always @(posedge i_clk) begin
        t_exp_res e;
        if (i_rst_n && res_if.valid && res_if.ready) begin
            if (due_results.size() == 0) begin
                n_err++;
                $display("%0t: result beat with nothing expected: action %0d dl %0b/%0h",
                         $time, res_if.action, res_if.deadline_valid, res_if.next_deadline);
            end else begin
                e = due_results.pop_front();
                n_checked++;
                if (res_if.action !== e.action) begin
                    n_err++;
                    $display("%0t: action mismatch: expected %0d actual %0d",
                             $time, e.action, res_if.action);
                end
                if (res_if.deadline_valid !== e.dl_valid) begin
                    n_err++;
                    $display("%0t: deadline_valid mismatch: expected %0b actual %0b",
                             $time, e.dl_valid, res_if.deadline_valid);
                end
                if (res_if.next_deadline !== e.deadline) begin
                    n_err++;
                    $display("%0t: next_deadline mismatch: expected %0h actual %0h",
                             $time, e.deadline, res_if.next_deadline);
                end
            end
        end
        res_if.ready <= calm || ($urandom_range(0, 99) >= IDLE_PCT);
    end

    always @(posedge i_clk) begin
        if ((item_if.valid && item_if.ready) || (res_if.valid && res_if.ready) ||
            (cfg_if.valid && cfg_if.ready))
            quiet_cycles = 0;
        else
            quiet_cycles++;
        if (quiet_cycles >= STALL_LIMIT) begin
            $display("%0t: watchdog, no beat for %0d cycles, %0d results outstanding",
                     $time, quiet_cycles, due_results.size());
            $display("DONE: errors detected");
            $finish;
        end
    end

    // leaves valid high after the beat; the next call replaces the beat or drops valid, and wait_idle drops it
    task automatic send_beat(input logic cmd, input logic raw, input logic [TB_TIME-1:0] t);
        t_exp_res r;
        while (!calm && $urandom_range(0, 99) < IDLE_PCT) begin
            item_if.valid <= 1'b0;
            @(posedge i_clk);
        end
        item_if.valid     <= 1'b1;
        item_if.command   <= cmd;
        item_if.raw_level <= raw;
        item_if.now       <= t;
        @(posedge i_clk);
        while (!item_if.ready) @(posedge i_clk);
        r = ptt_next_result(cmd, raw, t);
        due_results.push_back(r);
        n_beats++;
        if (cmd == CMD_TICK) n_ticks++;
        if (r.action == ACT_START) n_start++;
        if (r.action == ACT_STOP) n_stop++;
    endtask

    task automatic wait_idle();
        item_if.valid <= 1'b0;
        @(posedge i_clk);
        while (due_results.size() != 0) @(posedge i_clk);
        repeat (4) @(posedge i_clk);
    endtask

    task automatic write_reg(input logic [CFG_IDX_BITS-1:0] idx,
                             input logic [CFG_DATA_BITS-1:0] data);
        cfg_if.valid <= 1'b1;
        cfg_if.index <= idx;
        cfg_if.data  <= data;
        @(posedge i_clk);
        while (!cfg_if.ready) @(posedge i_clk);
        case (idx)
            CFG_DEBOUNCE: p_debounce = data;
            CFG_TAIL:     p_tail     = data;
            CFG_INVERT:   p_invert   = data[0];
            default: ;
        endcase
        n_cfg++;
    endtask

    task automatic load_cfg(input logic [15:0] deb, input logic [15:0] tail, input logic inv);
        wait_idle();
        write_reg(CFG_DEBOUNCE, deb);
        write_reg(CFG_TAIL, tail);
        write_reg(CFG_INVERT, {15'($urandom()), inv});
        cfg_if.valid <= 1'b0;
        @(posedge i_clk);
    endtask

    // bouncy finger on the key, occasional ticks and wild timestamps
    task automatic run_traffic(input int n, input logic [TB_TIME-1:0] base);
        logic [TB_TIME-1:0] t;
        logic               finger;
        logic               cmd;
        logic               lvl;
        int                 span;
        int                 r;
        t      = base;
        finger = 1'($urandom_range(0, 1));
        span   = (p_debounce > p_tail) ? int'(p_debounce) : int'(p_tail);
        for (int k = 0; k < n; k++) begin
            r = $urandom_range(0, 99);
            if (r < 4)
                t = 48'({$urandom(), $urandom()});
            else if (r < 14)
                t = t + 48'($urandom_range(0, span + span / 2 + 4));
            else
                t = t + 48'($urandom_range(0, int'(p_debounce) / 3 + 2));
            if ($urandom_range(0, 99) < 8) finger = ~finger;
            cmd = ($urandom_range(0, 99) < 12) ? CMD_TICK : CMD_SAMPLE;
            if (cmd == CMD_TICK || r < 4)
                lvl = 1'($urandom_range(0, 1));
            else
                lvl = ($urandom_range(0, 99) < 15) ? ~finger : finger;
            send_beat(cmd, lvl, t);
        end
    endtask

    task automatic test_directed_edges();
        // defaults: candidate at time zero never counts, zero debounce needs two samples
        send_beat(CMD_SAMPLE, 1'b0, 48'd0);
        send_beat(CMD_SAMPLE, 1'b0, 48'd0);
        send_beat(CMD_SAMPLE, 1'b0, 48'd7);
        send_beat(CMD_SAMPLE, 1'b0, 48'd7);
        send_beat(CMD_TICK,   1'b1, 48'd9);
        send_beat(CMD_SAMPLE, 1'b1, 48'd12);
        send_beat(CMD_SAMPLE, 1'b1, 48'd12);
        load_cfg(16'd20, 16'd100, 1'b0);
        send_beat(CMD_SAMPLE, 1'b0, 48'd100);
        send_beat(CMD_SAMPLE, 1'b0, 48'd115);
        send_beat(CMD_SAMPLE, 1'b1, 48'd118);
        send_beat(CMD_SAMPLE, 1'b0, 48'd120);
        send_beat(CMD_SAMPLE, 1'b0, 48'd140);
        send_beat(CMD_SAMPLE, 1'b1, 48'd200);
        send_beat(CMD_SAMPLE, 1'b1, 48'd225);
        send_beat(CMD_TICK,   1'b0, 48'd300);
        send_beat(CMD_SAMPLE, 1'b0, 48'd310);
        send_beat(CMD_SAMPLE, 1'b1, 48'd312);
        send_beat(CMD_TICK,   1'b1, 48'd325);
        // time running backwards
        send_beat(CMD_SAMPLE, 1'b0, 48'd500);
        send_beat(CMD_SAMPLE, 1'b0, 48'd400);
        // inverted sense, saturation at the top of the time range
        load_cfg(16'hFFFF, 16'hFFFF, 1'b1);
        send_beat(CMD_SAMPLE, 1'b1, T_MAX - 48'd10);
        send_beat(CMD_SAMPLE, 1'b1, T_MAX - 48'd5);
        load_cfg(16'd0, 16'hFFFF, 1'b1);
        send_beat(CMD_SAMPLE, 1'b1, T_MAX - 48'd3);
        send_beat(CMD_SAMPLE, 1'b1, T_MAX - 48'd3);
        send_beat(CMD_SAMPLE, 1'b0, T_MAX - 48'd2);
        send_beat(CMD_SAMPLE, 1'b0, T_MAX - 48'd1);
        send_beat(CMD_TICK,   1'b0, T_MAX);
    endtask

    task automatic test_short_timers();
        load_cfg(16'($urandom_range(0, 20)), 16'($urandom_range(1, 40)),
                 1'($urandom_range(0, 1)));
        run_traffic(200, 48'($urandom_range(1, 1000)));
    endtask

    task automatic test_max_timers();
        load_cfg(16'hFFFF, 16'hFFFF, 1'b1);
        run_traffic(100, T_MAX - 48'd200000);
    endtask

    task automatic test_zero_timers();
        load_cfg(16'd0, 16'd0, 1'b0);
        run_traffic(100, 48'd0);
    endtask

    task automatic test_wide_timers();
        load_cfg(16'($urandom()), 16'($urandom()), 1'($urandom_range(0, 1)));
        run_traffic(150, 48'({$urandom(), $urandom()}) >> 1);
    endtask

    task automatic test_steady_stream();
        load_cfg(16'd5, 16'd10, 1'b0);
        calm = 1'b1;
        run_traffic(100, 48'd50);
        wait_idle();
        calm = 1'b0;
    endtask

    initial begin
        i_rst_n           = 1'b0;
        item_if.valid     = 1'b0;
        item_if.command   = CMD_SAMPLE;
        item_if.raw_level = 1'b1;
        item_if.now       = '0;
        res_if.ready      = 1'b0;
        cfg_if.valid      = 1'b0;
        cfg_if.index      = CFG_DEBOUNCE;
        cfg_if.data       = '0;
        p_debounce        = '0;
        p_tail            = '0;
        p_invert          = 1'b0;
        st_pressed        = 1'b0;
        cand_down         = 1'b0;
        cand_start        = '0;
        tail_exp          = '0;
        tx_on             = 1'b0;
        n_err             = 0;
        n_beats           = 0;
        n_ticks           = 0;
        n_checked         = 0;
        n_start           = 0;
        n_stop            = 0;
        n_cfg             = 0;
        calm              = 1'b0;
        quiet_cycles      = 0;
        repeat (12) @(posedge i_clk);
        i_rst_n <= 1'b1;
        @(posedge i_clk);

        test_directed_edges();
        test_short_timers();
        test_max_timers();
        test_zero_timers();
        test_wide_timers();
        test_steady_stream();

        wait_idle();
        repeat (8) @(posedge i_clk);
        $display("Run: %0d beats in (%0d ticks), %0d results checked, %0d register writes",
                 n_beats, n_ticks, n_checked, n_cfg);
        $display("     transmit starts %0d, stops %0d, across six test groups",
                 n_start, n_stop);
        if (n_err == 0) begin
            $display("DONE: 0 errors");
        end else begin
            $display("DONE: errors detected");
        end
        $finish;
    end

endmodule
